[sv/huff_pkg.sv]
// Shared widths for the Huffman code builder.
`timescale 1ns / 1ps
package huff_pkg;
	localparam int IN_FREQ_W = 24;
	localparam int IN_DATA_W = 24;
	localparam int CODE_W    = 31;
	localparam int LEN_W     = 5;
	localparam int SYM_W     = 5;
	localparam int DEPTH_W   = 6;
	localparam int OUT_DATA_W = 48;
endpackage

[sv/huffman_code_builder_core.sv]
// Top level of the Huffman code builder: load, merge search and preorder code walk.
`timescale 1ns / 1ps
// Usage:
//   Slave stream: one word per symbol, tdata holds the frequency, tlast marks the
//   final symbol of a run. Words beyond MAX_SYMBOLS are dropped, but a tlast on
//   such a word still starts the build.
//   Master stream: one word per symbol in preorder leaf order; tdata holds
//   code_bits, code_length and symbol_index, tlast marks the final code.
//   After the final word the block merges the two lightest live nodes, once per
//   symbol minus one; each merge scans every node so far through the node memory
//   (one read a cycle) and then writes the parent. The walk then finds the root and
//   visits each tree node in preorder: an inner node reads its children and pushes
//   the right one on the walk stack, a leaf emits its code and pops the next node.
//   A stall on the output holds the walk at its next leaf.
//   The slave side is ready only while loading.
//   Reset: all control state clears, no node is live, the block waits for loads.
//   Stall: a code waits in the output register while tready is low and the walk
//   holds at its next leaf; loading of the next run may start while the final code still waits.
module huffman_code_builder_core
	import huff_pkg::*;
#(
	parameter int MAX_SYMBOLS = 32,
	parameter int FREQ_BITS   = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [23:0] frequency
	input  logic                  s_tlast,   // last_symbol
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [30:0] code_bits, [35:31] code_length,
	                                         // [40:36] symbol_index, [47:41] zero
	output logic                  m_tlast    // last_code
);
	localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
	localparam int NW  = $clog2(NODE_CAP);          // node index
	localparam int CW  = NW + 1;                    // counts
	localparam int WW  = FREQ_BITS + $clog2(MAX_SYMBOLS);
	localparam int SAW = $clog2(MAX_SYMBOLS);       // stack address
	localparam int SPW = SAW + 1;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_BSTRT = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_MERGE = 3'd3;
	localparam logic [2:0] ST_ROOT  = 3'd4;
	localparam logic [2:0] ST_VISIT = 3'd5;
	localparam logic [2:0] ST_CHILD = 3'd6;
	localparam logic [2:0] ST_POP   = 3'd7;

	typedef struct packed {
		logic [WW-1:0] weight;
		logic [NW-1:0] left;
		logic [NW-1:0] right;
	} node_t;

	typedef struct packed {
		logic [NW-1:0]      node;
		logic [CODE_W-1:0]  code;
		logic [DEPTH_W-1:0] depth;
	} walk_t;

	logic [2:0]          state_q;
	logic [CW-1:0]       node_cnt_q, sym_cnt_q, live_q, scan_q;
	logic [NODE_CAP-1:0] unmerged_q;

	// node memory: one write port, one registered read port
	node_t         node_mem [NODE_CAP];
	node_t         node_rd_q;
	logic [NW-1:0] node_raddr;
	logic          node_we;
	logic [NW-1:0] node_waddr;
	node_t         node_wdata;

	// walk stack memory
	walk_t          stk_mem [MAX_SYMBOLS];
	walk_t          stk_rd_q;
	logic [SPW-1:0] sp_q;
	logic           stk_we;
	walk_t          stk_wdata;

	// scan pipeline and the two lightest nodes found
	logic          vld_s1;
	logic [NW-1:0] idx_s1;
	logic          have_a_q, have_b_q;
	logic [NW-1:0] a_q, b_q;
	logic [WW-1:0] wa_q, wb_q;

	// walk cursor
	logic [NW-1:0]      cur_q;
	logic [CODE_W-1:0]  code_q;
	logic [DEPTH_W-1:0] depth_q;

	logic                  out_vld_q, out_last_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_free;
	logic                  emit;
	logic                  load_ok;
	logic                  is_leaf;
	logic [FREQ_BITS-1:0]  freq_in;

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign out_free = !out_vld_q || m_tready;
	assign emit     = (state_q == ST_VISIT) && is_leaf && out_free;
	assign load_ok  = sym_cnt_q < CW'(MAX_SYMBOLS);
	assign is_leaf  = CW'(cur_q) < sym_cnt_q;
	assign freq_in  = FREQ_BITS'(s_tdata[IN_FREQ_W-1:0]);

	// Memory address and write selection.
	always_comb begin
		node_raddr = (state_q == ST_SCAN) ? scan_q[NW-1:0] : cur_q;
		node_we    = 1'b0;
		node_waddr = sym_cnt_q[NW-1:0];
		node_wdata = '{weight: WW'(freq_in), left: '0, right: '0};
		if (state_q == ST_LOAD && s_tvalid && load_ok) begin
			node_we = 1'b1;
		end else if (state_q == ST_MERGE) begin
			node_we    = 1'b1;
			node_waddr = node_cnt_q[NW-1:0];
			node_wdata = '{weight: wa_q + wb_q, left: a_q, right: b_q};
		end
		stk_we    = (state_q == ST_CHILD);
		stk_wdata = '{node: node_rd_q.right, code: {code_q[CODE_W-2:0], 1'b1},
			depth: depth_q + DEPTH_W'(1)};
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem[node_raddr];
		if (stk_we) begin
			stk_mem[sp_q[SAW-1:0]] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[SAW'(sp_q - SPW'(1))];
	end

	// Compare stage of the scan: keep the two lightest, lowest index on ties.
	always_ff @(posedge clk) begin
		if (state_q == ST_BSTRT) begin
			have_a_q <= 1'b0;
			have_b_q <= 1'b0;
		end else if (vld_s1) begin
			if (!have_a_q || node_rd_q.weight < wa_q) begin
				b_q      <= a_q;
				wb_q     <= wa_q;
				have_b_q <= have_a_q;
				a_q      <= idx_s1;
				wa_q     <= node_rd_q.weight;
				have_a_q <= 1'b1;
			end else if (!have_b_q || node_rd_q.weight < wb_q) begin
				b_q      <= idx_s1;
				wb_q     <= node_rd_q.weight;
				have_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			node_cnt_q <= '0;
			sym_cnt_q  <= '0;
			live_q     <= '0;
			scan_q     <= '0;
			unmerged_q <= '0;
			sp_q       <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			cur_q      <= '0;
			code_q     <= '0;
			depth_q    <= '0;
			out_vld_q  <= 1'b0;
			out_last_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			// hold the code until taken, load a new one when the walk emits
			out_vld_q <= emit || (out_vld_q && !m_tready);
			unique case (state_q)
				ST_LOAD: begin
					if (s_tvalid) begin
						if (load_ok) begin
							unmerged_q[sym_cnt_q[NW-1:0]] <= 1'b1;
							sym_cnt_q  <= sym_cnt_q + CW'(1);
							node_cnt_q <= sym_cnt_q + CW'(1);
						end
						if (s_tlast) begin
							live_q  <= load_ok ? sym_cnt_q + CW'(1) : sym_cnt_q;
							state_q <= ST_BSTRT;
						end
					end
				end
				ST_BSTRT: begin
					vld_s1 <= 1'b0;
					scan_q <= '0;
					state_q <= (live_q > CW'(1)) ? ST_SCAN : ST_ROOT;
				end
				ST_SCAN: begin
					// issue one node read per cycle; the compare stage works on the registered read data and index
					if (scan_q < node_cnt_q) begin
						vld_s1 <= unmerged_q[scan_q[NW-1:0]];
						idx_s1 <= scan_q[NW-1:0];
						scan_q <= scan_q + CW'(1);
					end else begin
						vld_s1  <= 1'b0;
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					// retire both children, the new parent becomes live
					unmerged_q <= (unmerged_q & ~(NODE_CAP'(1) << a_q)
						& ~(NODE_CAP'(1) << b_q)) | (NODE_CAP'(1) << node_cnt_q[NW-1:0]);
					node_cnt_q <= node_cnt_q + CW'(1);
					live_q     <= live_q - CW'(1);
					state_q    <= ST_BSTRT;
				end
				ST_ROOT: begin
					cur_q   <= NW'(node_cnt_q - CW'(1));
					code_q  <= '0;
					depth_q <= '0;
					sp_q    <= '0;
					state_q <= ST_VISIT;
				end
				ST_VISIT: begin
					if (!is_leaf) begin
						state_q <= ST_CHILD;
					end else if (out_free) begin
						out_last_q <= (sp_q == '0);
						out_data_q <= OUT_DATA_W'({SYM_W'(cur_q), LEN_W'(depth_q), code_q});
						if (sp_q == '0) begin
							// run done: clear live flags and counts for the next run
							unmerged_q <= '0;
							node_cnt_q <= '0;
							sym_cnt_q  <= '0;
							state_q    <= ST_LOAD;
						end else begin
							sp_q    <= sp_q - SPW'(1);
							state_q <= ST_POP;
						end
					end
				end
				ST_CHILD: begin
					// push the right child, descend left
					sp_q    <= sp_q + SPW'(1);
					cur_q   <= node_rd_q.left;
					code_q  <= {code_q[CODE_W-2:0], 1'b0};
					depth_q <= depth_q + DEPTH_W'(1);
					state_q <= ST_VISIT;
				end
				ST_POP: begin
					cur_q   <= stk_rd_q.node;
					code_q  <= stk_rd_q.code;
					depth_q <= stk_rd_q.depth;
					state_q <= ST_VISIT;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_LOAD)
		else $error("input ready outside load");
	a_merge_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> have_a_q && have_b_q && a_q != b_q)
		else $error("merge without two distinct nodes");
	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_cnt_q <= CW'(NODE_CAP))
		else $error("node count overflow");
`endif
endmodule

[verif/huffman_code_builder_core_tb.sv]
// Testbench for the Huffman code builder: directed and random streams checked against a built-in predictor.
`timescale 1ns / 1ps
module huffman_code_builder_core_tb;
	import huff_pkg::*;

	localparam int MAX_SYM  = 32;
	localparam int NODE_CAP = 2 * MAX_SYM - 1;
	localparam int WDOG_MAX = 20000;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic [SYM_W-1:0]  sym;
		logic              last;
	} code_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;

	huffman_code_builder_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] wt [NODE_CAP];
	int lch [NODE_CAP];
	int rch [NODE_CAP];
	bit live [NODE_CAP];
	int nsym = 0;
	int nnode = 0;
	code_t code_q [$];
	int errors = 0;
	int burst_left = 0;
	int wdog = 0;
	bit stall_hi = 0;

	function automatic int lightest(int skip);
		int best;
		best = -1;
		for (int i = 0; i < nnode; i++)
			if (live[i] && i != skip && (best < 0 || wt[i] < wt[best]))
				best = i;
		return best;
	endfunction

	// load one frequency; on the final one build the tree and queue its codes
	task automatic predict_codes(logic [23:0] freq, logic fin);
		int a, b, sp, n, d;
		int stk_n [MAX_SYM + 1];
		logic [63:0] stk_c [MAX_SYM + 1];
		int stk_d [MAX_SYM + 1];
		logic [63:0] cc;
		code_t c;
		if (nsym < MAX_SYM) begin
			wt[nsym] = 32'(freq);
			live[nsym] = 1;
			nsym++;
			nnode = nsym;
		end
		if (!fin)
			return;
		for (int l = nsym; l > 1; l--) begin
			a = lightest(-1);
			b = lightest(a);
			wt[nnode] = wt[a] + wt[b];
			lch[nnode] = a;
			rch[nnode] = b;
			live[a] = 0;
			live[b] = 0;
			live[nnode] = 1;
			nnode++;
		end
		// preorder walk: right child pushed first, left on top
		stk_n[0] = nnode - 1;
		stk_c[0] = '0;
		stk_d[0] = 0;
		sp = 1;
		while (sp > 0) begin
			sp--;
			n = stk_n[sp];
			cc = stk_c[sp];
			d = stk_d[sp];
			if (n < nsym) begin
				c.bits = cc[CODE_W-1:0];
				c.len = LEN_W'(d);
				c.sym = SYM_W'(n);
				c.last = 1'b0;
				code_q = {code_q, c};
			end else begin
				stk_n[sp] = rch[n];
				stk_c[sp] = {cc[62:0], 1'b1};
				stk_d[sp] = d + 1;
				sp++;
				stk_n[sp] = lch[n];
				stk_c[sp] = {cc[62:0], 1'b0};
				stk_d[sp] = d + 1;
				sp++;
			end
		end
		code_q[$].last = 1;
		for (int i = 0; i < NODE_CAP; i++)
			live[i] = 0;
		nsym = 0;
		nnode = 0;
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	// send one word, idling in bursts; valid stays up between words of a burst
	task automatic send_word(logic [23:0] freq, logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 1) ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= freq;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_codes(freq, fin);
		@(negedge clk);
	endtask

	task automatic send_run(int n, int mode);
		logic [23:0] f;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: f = 24'($urandom);
				1: f = 24'($urandom_range(0, 7));
				2: f = 24'hFFFFFF;
				default: f = 24'(1 << (i % 24));
			endcase
			send_word(f, i == n - 1);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (code_q.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_run(1, 0);
		send_run(2, 2);
		send_word(0, 0);
		send_word(0, 1);
		send_run(32, 3);
		drain();
	endtask

	task automatic test_overflow();
		// words beyond capacity are dropped, the tlast still starts the build
		send_run(36, 1);
		drain();
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 300) begin
			automatic int n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
			                                                : $urandom_range(1, 8);
			send_run(n, $urandom_range(0, 3));
			sent += n;
		end
		drain();
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_hi <= ~stall_hi;
		m_tready <= stall_hi ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	// check each code word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (code_q.size() == 0) begin
				report_mismatch("unexpected code word");
			end else begin
				automatic code_t e = code_q.pop_front();
				if (m_tdata[30:0] !== e.bits)
					report_mismatch($sformatf("code_bits %h exp %h", m_tdata[30:0], e.bits));
				if (m_tdata[35:31] !== e.len)
					report_mismatch($sformatf("code_length %0d exp %0d", m_tdata[35:31], e.len));
				if (m_tdata[40:36] !== e.sym)
					report_mismatch($sformatf("symbol_index %0d exp %0d", m_tdata[40:36], e.sym));
				if (m_tdata[47:41] !== '0)
					report_mismatch("nonzero pad bits");
				if (m_tlast !== e.last)
					report_mismatch($sformatf("last_code %b exp %b", m_tlast, e.last));
			end
		end
	end

	// watchdog: cycles with no accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NODE_CAP; i++)
			live[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_overflow();
		test_random();
		if (code_q.size() != 0)
			report_mismatch("codes left over");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

[sim.f]
sv/huff_pkg.sv
sv/huffman_code_builder_core.sv
verif/huffman_code_builder_core_tb.sv
